FILE: sv/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Request and result types, opcodes and controller states for the sorted
// key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_ACCESS   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic               found;
    logic [COUNT_W-1:0] entry_count;
    logic               full_flag;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_MOVE
  } state_t;

endpackage

FILE: sv/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order in two synchronous RAMs;
// lookup by binary search, insert and erase by shifting entries.
// ----------------------------------------------------------------------------
//  channel   signals               direction  accepted when
//  request   start, request        in         start && !busy
//  result    done, result          out        every cycle done is high
//
//  Clear and unused opcodes are answered from idle, with no search. Other
//  requests run a binary search (one RAM read, one compare per step), then
//  insert or erase shifts entries, one entry per cycle through the single
//  read port. Synchronous reset empties the table at once; the RAMs are not
//  cleared. The result strobe lasts one cycle and cannot be stalled; a new
//  request may start in the cycle the result is shown.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 64,
  parameter int VALUE_BITS  = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  skvt_pkg::req_t request,
  output logic          done,
  output skvt_pkg::rsp_t result
);
  import skvt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // storage
  logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  // control
  state_t                state, state_next;
  logic [OP_W-1:0]       op, op_next;
  logic [KEY_BITS-1:0]   key_q, key_q_next;
  logic [VALUE_BITS-1:0] val_q, val_q_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         moves, moves_next;
  logic [AW-1:0]         idx, idx_next;
  logic [AW-1:0]         last, last_next;
  logic                  fin, fin_next;
  logic                  pend, pend_next;
  logic                  dn, dn_next;
  logic                  done_next;
  rsp_t                  result_next;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [KEY_BITS-1:0]   wk;
  logic [VALUE_BITS-1:0] wv;
  logic [CW-1:0]         mid;
  logic                  hit;

  function automatic rsp_t make_rsp(input logic [VALUE_BITS-1:0] v, input logic f,
                                    input logic [CW-1:0] c, input logic full);
    rsp_t r;
    r.value_out   = VALUE_W'(v);
    r.found       = f;
    r.entry_count = COUNT_W'(c);
    r.full_flag   = full;
    return r;
  endfunction

  assign mid  = lo + ((hi - lo) >> 1);
  assign hit  = (lo < count) && (key_rd == key_q);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wk;
      val_mem[wa] <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      pend  <= pend_next;
    end
    op     <= op_next;
    key_q  <= key_q_next;
    val_q  <= val_q_next;
    lo     <= lo_next;
    hi     <= hi_next;
    moves  <= moves_next;
    idx    <= idx_next;
    last   <= last_next;
    fin    <= fin_next;
    dn     <= dn_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    key_q_next  = key_q;
    val_q_next  = val_q;
    lo_next     = lo;
    hi_next     = hi;
    count_next  = count;
    moves_next  = moves;
    idx_next    = idx;
    last_next   = last;
    fin_next    = fin;
    pend_next   = pend;
    dn_next     = dn;
    done_next   = 1'b0;
    result_next = result;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    wa          = '0;
    wk          = key_q;
    wv          = val_q;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = request.opcode;
          key_q_next = request.key[KEY_BITS-1:0];
          val_q_next = request.value_in[VALUE_BITS-1:0];
          lo_next    = '0;
          hi_next    = count;
          if (request.opcode == OP_CLEAR) begin
            count_next  = '0;
            done_next   = 1'b1;
            result_next = make_rsp('0, 1'b0, '0, 1'b0);
          end else if (request.opcode > OP_CLEAR) begin
            done_next   = 1'b1;
            result_next = make_rsp('0, 1'b0, count, 1'b0);
          end else begin
            state_next = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (lo < hi) begin
          rd_en    = 1'b1;
          rd_addr  = mid[AW-1:0];
          fin_next = 1'b0;
        end else begin
          // final read at the lower bound, only if it holds an entry
          rd_en    = (lo < count);
          rd_addr  = lo[AW-1:0];
          fin_next = 1'b1;
        end
        state_next = S_CMP;
      end

      S_CMP: begin
        if (!fin) begin
          if (key_rd < key_q) lo_next = mid + CW'(1);
          else                hi_next = mid;
          state_next = S_PROBE;
        end else begin
          state_next = S_IDLE;
          case (op)
            OP_CONTAINS: begin
              done_next   = 1'b1;
              result_next = make_rsp('0, hit, count, 1'b0);
            end
            OP_ACCESS, OP_WRITE: begin
              if (hit) begin
                if (op == OP_WRITE) begin
                  we = 1'b1;
                  wa = lo[AW-1:0];
                  wv = val_q;
                end
                done_next   = 1'b1;
                result_next = make_rsp((op == OP_WRITE) ? val_q : val_rd, 1'b1, count, 1'b0);
              end else if (count >= CW'(TABLE_DEPTH)) begin
                done_next   = 1'b1;
                result_next = make_rsp('0, 1'b0, count, 1'b1);
              end else begin
                moves_next = count - lo;
                idx_next   = AW'(count - CW'(1));
                dn_next    = 1'b0;
                pend_next  = 1'b0;
                state_next = S_MOVE;
              end
            end
            OP_ERASE: begin
              if (hit) begin
                moves_next = count - lo - CW'(1);
                idx_next   = AW'(lo + CW'(1));
                dn_next    = 1'b1;
                pend_next  = 1'b0;
                state_next = S_MOVE;
              end else begin
                done_next   = 1'b1;
                result_next = make_rsp('0, 1'b0, count, 1'b0);
              end
            end
            default: begin
              done_next   = 1'b1;
              result_next = make_rsp('0, 1'b0, count, 1'b0);
            end
          endcase
        end
      end

      S_MOVE: begin
        // read one entry per cycle, write it one slot over the next cycle
        if (pend) begin
          we = 1'b1;
          wa = dn ? (last - AW'(1)) : (last + AW'(1));
          wk = key_rd;
          wv = val_rd;
        end
        if (moves != '0) begin
          rd_en      = 1'b1;
          rd_addr    = idx;
          last_next  = idx;
          idx_next   = dn ? (idx + AW'(1)) : (idx - AW'(1));
          moves_next = moves - CW'(1);
          pend_next  = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            if (dn) begin
              count_next  = count - CW'(1);
              result_next = make_rsp('0, 1'b1, count - CW'(1), 1'b0);
            end else begin
              we          = 1'b1;
              wa          = lo[AW-1:0];
              wk          = key_q;
              wv          = (op == OP_WRITE) ? val_q : '0;
              count_next  = count + CW'(1);
              result_next = make_rsp((op == OP_WRITE) ? val_q : '0, 1'b0,
                                     count + CW'(1), 1'b0);
            end
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while controller busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && result.full_flag |-> !result.found && count == CW'(TABLE_DEPTH))
    else $error("refused insert while table not full");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request produced neither work nor result");

  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |-> moves <= count)
    else $error("shift length exceeds entry count");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_value_table. A shadow copy of the table
// predicts each result. A clocked driver issues requests from a queue, and a
// clocked monitor compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skvt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 1650;
  localparam int TAIL_CYCLES = 64;
  localparam int DRAIN_EVERY = 500;
  localparam int MAX_PRINTS  = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;

  sorted_key_value_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  // shadow table
  logic [KEY_W-1:0]   shadow_keys [DEPTH];
  logic [VALUE_W-1:0] shadow_vals [DEPTH];
  int                 shadow_count = 0;

  req_t pending_reqs [$];
  rsp_t awaited_rsp [$];
  rsp_t want_rsp;

  int total_reqs = 0;
  int n_issued = 0;
  int errors = 0;
  int op_tally [1 << OP_W];
  int refused_inserts = 0;
  int hits = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Applies one request to the shadow table and returns the result it gives.
  function automatic rsp_t apply_table_op(req_t rq);
    rsp_t r;
    int   pos;
    bit   hit;
    r = '0;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < rq.key) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == rq.key);
    case (rq.opcode)
      OP_ACCESS, OP_WRITE: begin
        if (hit) begin
          r.found = 1'b1;
          if (rq.opcode == OP_WRITE) shadow_vals[pos] = rq.value_in;
          r.value_out = shadow_vals[pos];
        end else if (shadow_count >= DEPTH) begin
          r.full_flag = 1'b1;
        end else begin
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[pos] = rq.key;
          shadow_vals[pos] = (rq.opcode == OP_WRITE) ? rq.value_in : '0;
          shadow_count++;
          r.value_out = shadow_vals[pos];
        end
      end
      OP_CONTAINS: r.found = hit;
      OP_ERASE: begin
        if (hit) begin
          r.found = 1'b1;
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_count--;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.entry_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    req_t rq;
    rq.opcode = op;
    rq.key = k;
    rq.value_in = v;
    pending_reqs.push_back(rq);
    total_reqs++;
  endtask

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        awaited_rsp.push_back(apply_table_op(request));
        op_tally[request.opcode]++;
        if (awaited_rsp[$].full_flag) refused_inserts++;
        if (awaited_rsp[$].found) hits++;
      end
      if (start && busy) begin
        // hold the current request
      end else if (pending_reqs.size() != 0 &&
                   !(n_issued % DRAIN_EVERY == DRAIN_EVERY / 2 &&
                     awaited_rsp.size() != 0) &&
                   $urandom_range(0, 99) >= (n_issued < total_reqs / 3 ? 26 :
                                             n_issued < 2 * total_reqs / 3 ? 50 : 0)) begin
        start <= 1'b1;
        request <= pending_reqs.pop_front();
        n_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        report_error("result strobe with no request outstanding");
      end else begin
        want_rsp = awaited_rsp.pop_front();
        if (result.value_out !== want_rsp.value_out)
          report_error($sformatf("value_out %h, want %h", result.value_out,
                                 want_rsp.value_out));
        if (result.found !== want_rsp.found)
          report_error($sformatf("found %b, want %b", result.found, want_rsp.found));
        if (result.entry_count !== want_rsp.entry_count)
          report_error($sformatf("entry_count %0d, want %0d", result.entry_count,
                                 want_rsp.entry_count));
        if (result.full_flag !== want_rsp.full_flag)
          report_error($sformatf("full_flag %b, want %b", result.full_flag,
                                 want_rsp.full_flag));
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] pool [32];
    int               pool_size;
    int               n_rand;
    int               ep_len;
    int               pick;
    logic [KEY_W-1:0] k;

    foreach (op_tally[i]) op_tally[i] = 0;

    // directed: empty table, extreme keys and values, every opcode
    queue_req(OP_CONTAINS, '0, '0);
    queue_req(OP_ERASE, '0, '1);
    queue_req(OP_ACCESS, '0, '1);
    queue_req(OP_WRITE, '1, '1);
    queue_req(OP_WRITE, '0, 64'h8000_0000_0000_0001);
    queue_req(OP_ACCESS, '1, '0);
    queue_req(OP_ACCESS, '0, '0);
    queue_req(OP_CONTAINS, '1, '0);
    queue_req(OP_CONTAINS, 64'h8000_0000_0000_0000, '1);
    queue_req(OP_ERASE, 64'h0000_0000_0000_0001, '0);
    queue_req(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
    queue_req(OP_ERASE, '0, '0);
    for (int op = OP_CLEAR + 1; op < (1 << OP_W); op++)
      queue_req(op[OP_W-1:0], '1, '1);
    queue_req(OP_ERASE, '1, '0);
    queue_req(OP_CLEAR, '1, '1);
    queue_req(OP_CONTAINS, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    queue_req(OP_ACCESS, 64'h7FFF_FFFF_FFFF_FFFF, '1);

    // random: episodes over a small key pool so the table fills and drains
    n_rand = 0;
    while (n_rand < RANDOM_REQS) begin
      pool_size = $urandom_range(4, 28);
      for (int i = 0; i < pool_size; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) pool[i] = '0;
        else if (pick == 1) pool[i] = '1;
        else if (pick == 2 && i > 0) pool[i] = pool[i-1] + 1'b1;
        else pool[i] = rand64();
      end
      if ($urandom_range(0, 3) == 0) begin
        // fill burst: fresh keys until inserts get refused
        for (int i = 0; i < DEPTH + 3; i++) queue_req(OP_WRITE, rand64(), rand64());
        n_rand += DEPTH + 3;
      end
      ep_len = $urandom_range(40, 120);
      for (int i = 0; i < ep_len; i++) begin
        k = pool[$urandom_range(0, pool_size - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 22) queue_req(OP_ACCESS, k, rand64());
        else if (pick < 50) queue_req(OP_WRITE, k, rand64());
        else if (pick < 65) queue_req(OP_CONTAINS, k, rand64());
        else if (pick < 85) queue_req(OP_ERASE, k, rand64());
        else if (pick < 88) queue_req(OP_CLEAR, k, rand64());
        else if (pick < 92) queue_req(OP_W'(OP_CLEAR + $urandom_range(1, 3)), k, rand64());
        else queue_req(OP_W'($urandom_range(0, (1 << OP_W) - 1)), rand64(), rand64());
      end
      n_rand += ep_len;
    end

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: access %0d, write %0d, contains %0d, erase %0d, clear %0d",
             total_reqs, op_tally[OP_ACCESS], op_tally[OP_WRITE], op_tally[OP_CONTAINS],
             op_tally[OP_ERASE], op_tally[OP_CLEAR]);
    $display("Unused opcodes %0d, key hits %0d, refused inserts %0d, mismatches %0d",
             op_tally[5] + op_tally[6] + op_tally[7], hits, refused_inserts, errors);
    if (errors == 0) begin
      $display("sorted_key_value_table test passed");
    end else begin
      $display("sorted_key_value_table test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ERROR: run did not finish in time");
    $display("sorted_key_value_table test failed");
    $finish;
  end

endmodule
